@@ rtl/qprot_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qprot_pkg
// Shared types and codes of the quaternion product and rotate unit: word
// format, request and result payloads, operation codes.
// ----------------------------------------------------------------------------
package qprot_pkg;

    // Word format: signed two's complement, Q3.20 by default
    localparam int WORD_BITS     = 24;
    localparam int FRAC_BITS_DEF = 20;

    // Register stages through one Hamilton product unit
    localparam int QMUL_LAT = 3;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Operation codes
    localparam logic [1:0] MODE_MUL  = 2'd0;   // A * B
    localparam logic [1:0] MODE_ROT  = 2'd1;   // A * v * conj(A)
    localparam logic [1:0] MODE_CONJ = 2'd2;   // conj(A)
    localparam logic [1:0] MODE_NONE = 2'd3;   // unused code, all-zero result

    typedef struct packed {
        t_word w;
        t_word x;
        t_word y;
        t_word z;
    } t_quat;

    typedef struct packed {
        logic [1:0] mode;
        t_word      a_w;
        t_word      a_x;
        t_word      a_y;
        t_word      a_z;
        t_word      b_w;
        t_word      b_x;
        t_word      b_y;
        t_word      b_z;
    } t_req;

    typedef struct packed {
        t_word res_w;
        t_word res_x;
        t_word res_y;
        t_word res_z;
        logic  overflow;
    } t_res;

endpackage
`default_nettype wire

@@ rtl/qprot_qmul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qprot_qmul
// Pipelined Hamilton product P * Q, or P * conj(Q) when i_conj is set.
// Three stages: sixteen products, signed four-term sums with rounding half,
// then shift, saturate and overflow detect.
// ----------------------------------------------------------------------------
module qprot_qmul #(
    parameter int FRAC_BITS = qprot_pkg::FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_conj,
    input  wire qprot_pkg::t_quat i_p,
    input  wire qprot_pkg::t_quat i_q,
    output logic                  o_valid,
    output qprot_pkg::t_quat      o_r,
    output logic                  o_ovf
);

    localparam int W      = qprot_pkg::WORD_BITS;
    localparam int PROD_W = 2 * W;
    localparam int SUM_W  = 2 * W + 3;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_sum HALF = t_sum'(1) <<< (FRAC_BITS - 1);

    // Term k of component c is p[k] * q[c ^ k]; bit k marks a subtracted term
    localparam logic [3:0] NEG_BASE [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    qprot_pkg::t_word p_arr [4];
    qprot_pkg::t_word q_arr [4];

    t_prod            r_prod [4][4];
    logic  [3:0]      r_neg  [4];
    t_sum             r_sum  [4];
    t_sum             n_sum  [4];
    qprot_pkg::t_word n_res  [4];
    logic  [3:0]      n_sat;
    logic  [2:0]      r_v;

    assign p_arr[0] = i_p.w;
    assign p_arr[1] = i_p.x;
    assign p_arr[2] = i_p.y;
    assign p_arr[3] = i_p.z;
    assign q_arr[0] = i_q.w;
    assign q_arr[1] = i_q.x;
    assign q_arr[2] = i_q.y;
    assign q_arr[3] = i_q.z;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // Stage 1: products; conjugating Q flips every term on a vector part of Q
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[c][k] <= p_arr[k] * q_arr[2'(c ^ k)];
                r_neg[c][k]  <= NEG_BASE[c][k] ^ (i_conj & (c != k));
            end
        end
    end

    // Stage 2: exact signed sum plus rounding half
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sum[c] = HALF;
            for (int k = 0; k < 4; k++) begin
                if (r_neg[c][k]) begin
                    n_sum[c] = n_sum[c] - t_sum'(r_prod[c][k]);
                end else begin
                    n_sum[c] = n_sum[c] + t_sum'(r_prod[c][k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // Stage 3: arithmetic shift, clamp to the word when the top bits disagree
    always_comb begin
        t_sum               sh;
        logic [SUM_W-W:0]   hi;
        for (int c = 0; c < 4; c++) begin
            sh = r_sum[c] >>> FRAC_BITS;
            hi = sh[SUM_W-1:W-1];
            n_sat[c] = !((&hi) || !(|hi));
            if (n_sat[c]) begin
                n_res[c] = r_sum[c][SUM_W-1] ? qprot_pkg::WORD_MIN : qprot_pkg::WORD_MAX;
            end else begin
                n_res[c] = sh[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_r.w <= n_res[0];
        o_r.x <= n_res[1];
        o_r.y <= n_res[2];
        o_r.z <= n_res[3];
        o_ovf <= |n_sat;
    end

    assign o_valid = r_v[2];

endmodule
`default_nettype wire

@@ rtl/quaternion_product_rotate_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_product_rotate_unit
// Quaternion product, vector rotation and conjugate in Q3.20 fixed point,
// with rounding, saturation and an overflow flag.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with start high; busy is always low,
// since the pipeline never stalls and the receiver cannot hold results off.
// One request per cycle is sustained. Each result is on o_res for one cycle,
// marked by o_strobe. A request passes an input register, two three-stage
// Hamilton product units in series (the second one forms the outer product
// of a rotation) and an output register. Products and conjugates pass the
// second unit by a delay line, so every operation has the same latency and
// results leave in request order.
// ----------------------------------------------------------------------------
module quaternion_product_rotate_unit #(
    parameter int FRAC_BITS = qprot_pkg::FRAC_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire qprot_pkg::t_req i_req,
    output logic                 o_strobe,
    output qprot_pkg::t_res      o_res
);

    localparam int LAT = qprot_pkg::QMUL_LAT;

    typedef struct packed {
        logic [1:0]       mode;
        qprot_pkg::t_quat a;
    } t_side1;

    typedef struct packed {
        logic [1:0]       mode;
        qprot_pkg::t_quat a;
        qprot_pkg::t_quat t;
        logic             ovf;
    } t_side2;

    logic             r_v0;
    qprot_pkg::t_req  r_req0;
    qprot_pkg::t_quat req_a;
    qprot_pkg::t_quat u1_p;
    qprot_pkg::t_quat u1_q;
    logic             u1_conj;
    logic             u1_valid;
    qprot_pkg::t_quat u1_r;
    logic             u1_ovf;
    logic             u2_valid;
    qprot_pkg::t_quat u2_r;
    logic             u2_ovf;
    t_side1           r_d1 [LAT];
    t_side2           r_d2 [LAT];
    t_side2           tail;
    qprot_pkg::t_res  n_res;
    logic             r_strobe;
    qprot_pkg::t_res  r_res;

    // Never stalls
    assign busy = 1'b0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req0 <= i_req;
        end
    end

    // First unit: A * B, or the inner product v * conj(A) of a rotation
    assign req_a = '{w: r_req0.a_w, x: r_req0.a_x, y: r_req0.a_y, z: r_req0.a_z};

    always_comb begin
        u1_conj = (r_req0.mode == qprot_pkg::MODE_ROT);
        if (u1_conj) begin
            u1_p = '{w: '0, x: r_req0.b_x, y: r_req0.b_y, z: r_req0.b_z};
            u1_q = req_a;
        end else begin
            u1_p = req_a;
            u1_q = '{w: r_req0.b_w, x: r_req0.b_x, y: r_req0.b_y, z: r_req0.b_z};
        end
    end

    qprot_qmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_qmul_inner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_conj  (u1_conj),
        .i_p     (u1_p),
        .i_q     (u1_q),
        .o_valid (u1_valid),
        .o_r     (u1_r),
        .o_ovf   (u1_ovf)
    );

    // Mode and A ride alongside the first unit
    always_ff @(posedge i_clk) begin
        r_d1[0] <= '{mode: r_req0.mode, a: req_a};
        for (int i = 1; i < LAT; i++) begin
            r_d1[i] <= r_d1[i-1];
        end
    end

    // Second unit: outer product A * t of a rotation
    qprot_qmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_qmul_outer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (u1_valid),
        .i_conj  (1'b0),
        .i_p     (r_d1[LAT-1].a),
        .i_q     (u1_r),
        .o_valid (u2_valid),
        .o_r     (u2_r),
        .o_ovf   (u2_ovf)
    );

    // First-unit result and A ride alongside the second unit
    always_ff @(posedge i_clk) begin
        r_d2[0] <= '{mode: r_d1[LAT-1].mode, a: r_d1[LAT-1].a, t: u1_r, ovf: u1_ovf};
        for (int i = 1; i < LAT; i++) begin
            r_d2[i] <= r_d2[i-1];
        end
    end

    assign tail = r_d2[LAT-1];

    // Result select per operation; conjugate negation of the minimum saturates to the maximum
    always_comb begin
        n_res = '0;
        case (tail.mode)
            qprot_pkg::MODE_MUL: begin
                n_res = '{res_w: tail.t.w, res_x: tail.t.x, res_y: tail.t.y,
                          res_z: tail.t.z, overflow: tail.ovf};
            end
            qprot_pkg::MODE_ROT: begin
                n_res = '{res_w: '0, res_x: u2_r.x, res_y: u2_r.y,
                          res_z: u2_r.z, overflow: tail.ovf | u2_ovf};
            end
            qprot_pkg::MODE_CONJ: begin
                n_res.res_w = tail.a.w;
                n_res.res_x = (tail.a.x == qprot_pkg::WORD_MIN) ? qprot_pkg::WORD_MAX
                                                                : -tail.a.x;
                n_res.res_y = (tail.a.y == qprot_pkg::WORD_MIN) ? qprot_pkg::WORD_MAX
                                                                : -tail.a.y;
                n_res.res_z = (tail.a.z == qprot_pkg::WORD_MIN) ? qprot_pkg::WORD_MAX
                                                                : -tail.a.z;
                n_res.overflow = (tail.a.x == qprot_pkg::WORD_MIN)
                              || (tail.a.y == qprot_pkg::WORD_MIN)
                              || (tail.a.z == qprot_pkg::WORD_MIN);
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= u2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Every request yields exactly one strobe after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_strobe)
        else $error("request without result at fixed latency");

    // Rotation leaves a zero scalar part
    a_rot_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u2_valid && tail.mode == qprot_pkg::MODE_ROT) |=> (o_res.res_w == '0))
        else $error("rotation scalar part not zero");

    // Unused code gives an all-zero result without overflow
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u2_valid && tail.mode == qprot_pkg::MODE_NONE) |=> (o_res == '0))
        else $error("unused code gave a non-zero result");

    // Conjugate keeps the scalar part of A
    a_conj_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u2_valid && tail.mode == qprot_pkg::MODE_CONJ)
            |=> (o_res.res_w == $past(tail.a.w)))
        else $error("conjugate scalar part altered");

endmodule
`default_nettype wire
